>>> rtl/apwr_pkg.sv
// Shared types, encodings and helper functions for the ARM64 peephole window rewriter.
package apwr_pkg;

  // Largest buffer the counter is sized for; the NOP count saturates at it.
  localparam int MAX_WORDS = 65536;
  localparam int NOP_CNT_W = 17;
  localparam logic [NOP_CNT_W-1:0] NOP_CAP =
      NOP_CNT_W'((MAX_WORDS < 'h1FFFF) ? MAX_WORDS : 'h1FFFF);

  // Output queue depth: must be a power of two and at least two.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Instruction encodings
  localparam logic [31:0] NOP_WORD    = 32'hD503201F;
  localparam logic [31:0] STR_X_BASE  = 32'hF9000000;
  localparam logic [31:0] LDR_X_BASE  = 32'hF9400000;
  localparam logic [31:0] STR_W_BASE  = 32'hB9000000;
  localparam logic [31:0] LDR_W_BASE  = 32'hB9400000;
  localparam logic [31:0] STP_X_BASE  = 32'hA9000000;
  localparam logic [31:0] LDP_X_BASE  = 32'hA9400000;
  localparam logic [31:0] MOV_REG_PAT = 32'hAA0003E0;
  localparam logic [31:0] MOV_REG_MSK = 32'hFFE0FFE0;
  localparam logic [31:0] CMP_IMM_PAT = 32'hF100001F;
  localparam logic [31:0] CMP_IMM_MSK = 32'hFF00001F;
  localparam logic [31:0] BCOND_PAT   = 32'h54000000;
  localparam logic [31:0] BCOND_MSK   = 32'hFF000010;
  localparam logic [31:0] CBZ_BASE    = 32'hB4000000;
  localparam logic [31:0] CBNZ_BASE   = 32'hB5000000;
  localparam logic [31:0] SUBS_PAT    = 32'hEB000000;
  localparam logic [31:0] SUBS_MSK    = 32'hFFE0FC00;
  localparam logic [31:0] MOVZ_PAT    = 32'hD2800000;
  localparam logic [31:0] MOVK_PAT    = 32'hF2800000;
  localparam logic [31:0] MOVW_MSK    = 32'hFF800000;
  localparam logic [31:0] TOP10_MSK   = 32'hFFC00000;
  localparam logic [5:0]  B_OPC       = 6'b000101;
  localparam logic [4:0]  REG_ZR      = 5'd31;

  // Branch condition codes
  localparam logic [3:0] COND_EQ = 4'h0;
  localparam logic [3:0] COND_NE = 4'h1;
  localparam logic [3:0] COND_AL = 4'hE;

  typedef struct packed {
    logic [31:0] instr_word;
    logic        is_final;
  } apwr_in_t;

  typedef struct packed {
    logic [31:0]          out_word;
    logic                 end_of_run;
    logic [NOP_CNT_W-1:0] nop_total;
  } apwr_out_t;

  typedef struct packed {
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic        skip;
    logic        hit;
  } apwr_match_t;

  function automatic logic top10(input logic [31:0] w, input logic [31:0] base);
    return (w & TOP10_MSK) == base;
  endfunction

  // MOV Xd,Xd written as ORR Xd,XZR,Xd
  function automatic logic is_self_mov(input logic [31:0] w);
    return ((w & MOV_REG_MSK) == MOV_REG_PAT) && (w[4:0] == w[20:16]);
  endfunction

  function automatic logic [NOP_CNT_W-1:0] sat_inc(input logic [NOP_CNT_W-1:0] c);
    return (c < NOP_CAP) ? c + NOP_CNT_W'(1) : c;
  endfunction

endpackage

>>> rtl/apwr_match.sv
// Pattern check of one window position against the following word.
module apwr_match
  import apwr_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        third_i,
  output apwr_match_t res_o
);

  logic [4:0]  rt_a, rt_b, rn_a, rn_b, rm_a, rm_b;
  logic [11:0] imm_a, imm_b;
  logic        pair_common, pair_st, pair_ld;
  logic        st_ld, dup_st, subs_cmp, cmp_br, bc_over_b, movz_movk;
  logic [18:0] cb_off;
  logic [26:0] bc_off;
  logic        bc_fits;

  assign rt_a  = a_i[4:0];
  assign rt_b  = b_i[4:0];
  assign rn_a  = a_i[9:5];
  assign rn_b  = b_i[9:5];
  assign rm_a  = a_i[20:16];
  assign rm_b  = b_i[20:16];
  assign imm_a = a_i[21:10];
  assign imm_b = b_i[21:10];

  assign pair_common = (rn_a == rn_b) && (rt_a != rt_b) &&
                       (imm_b == imm_a + 12'd1) && (imm_a <= 12'd63);
  assign pair_st = top10(a_i, STR_X_BASE) && top10(b_i, STR_X_BASE) && pair_common;
  // a load that overwrites its own base cannot be paired
  assign pair_ld = top10(a_i, LDR_X_BASE) && top10(b_i, LDR_X_BASE) && pair_common &&
                   (rt_a != rn_a);

  assign st_ld = ((top10(a_i, STR_X_BASE) && top10(b_i, LDR_X_BASE)) ||
                  (top10(a_i, STR_W_BASE) && top10(b_i, LDR_W_BASE))) &&
                 (rt_a == rt_b) && (rn_a == rn_b) && (imm_a == imm_b);

  assign dup_st = (a_i == b_i) && (top10(a_i, STR_X_BASE) || top10(a_i, STR_W_BASE));

  assign subs_cmp = ((a_i & SUBS_MSK) == SUBS_PAT) && ((b_i & SUBS_MSK) == SUBS_PAT) &&
                    (rt_b == REG_ZR) && (rn_a == rn_b) && (rm_a == rm_b);

  // CBZ/CBNZ offset: branch offset plus one, rejected at the positive limit
  assign cb_off = b_i[23:5] + 19'd1;
  assign cmp_br = ((a_i & CMP_IMM_MSK) == CMP_IMM_PAT) && (imm_a == 12'd0) &&
                  (rn_a != REG_ZR) && ((b_i & BCOND_MSK) == BCOND_PAT) &&
                  (b_i[3:0] <= COND_NE) && (b_i[23:5] != 19'h3FFFF);

  assign bc_off  = {b_i[25], b_i[25:0]} + 27'd1;
  assign bc_fits = (bc_off[26:18] == 9'h000) || (bc_off[26:18] == 9'h1FF);
  assign bc_over_b = third_i && ((a_i & BCOND_MSK) == BCOND_PAT) && (a_i[3:0] < COND_AL) &&
                     (b_i[31:26] == B_OPC) && (a_i[23:5] == 19'd2) && bc_fits;

  assign movz_movk = ((a_i & MOVW_MSK) == MOVZ_PAT) && ((b_i & MOVW_MSK) == MOVK_PAT) &&
                     (rt_a == rt_b) && (a_i[22:21] == 2'd0) && (a_i[20:5] == 16'd0) &&
                     (b_i[22:21] == 2'd0);

  always_comb begin
    res_o.word_a = a_i;
    res_o.word_b = b_i;
    res_o.skip   = 1'b0;
    res_o.hit    = 1'b1;
    if (pair_st || pair_ld) begin
      res_o.word_a = (pair_ld ? LDP_X_BASE : STP_X_BASE) |
                     {11'd0, imm_a[5:0], rt_b, rn_a, rt_a};
      res_o.word_b = NOP_WORD;
      res_o.skip   = 1'b1;
    end else if (st_ld) begin
      res_o.word_b = NOP_WORD;
    end else if (dup_st) begin
      res_o.word_a = NOP_WORD;
    end else if (subs_cmp) begin
      res_o.word_b = NOP_WORD;
      res_o.skip   = 1'b1;
    end else if (cmp_br) begin
      res_o.word_a = ((b_i[3:0] == COND_EQ) ? CBZ_BASE : CBNZ_BASE) |
                     {8'd0, cb_off, rn_a};
      res_o.word_b = NOP_WORD;
      res_o.skip   = 1'b1;
    end else if (bc_over_b) begin
      res_o.word_a = BCOND_PAT | {8'd0, bc_off[18:0], 1'b0, a_i[3:1], ~a_i[0]};
      res_o.word_b = NOP_WORD;
      res_o.skip   = 1'b1;
    end else if (movz_movk) begin
      res_o.word_a = MOVZ_PAT | {11'd0, b_i[20:5], rt_a};
      res_o.word_b = NOP_WORD;
      res_o.skip   = 1'b1;
    end else if (is_self_mov(a_i)) begin
      res_o.word_a = NOP_WORD;
    end else begin
      res_o.hit = 1'b0;
    end
  end

endmodule

>>> rtl/apwr_out_fifo.sv
// Small result queue that takes up to two items per cycle and hands out one.
module apwr_out_fifo
  import apwr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] push_cnt_i,
  input  apwr_out_t push0_i,
  input  apwr_out_t push1_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output apwr_out_t out_data_o
);

  apwr_out_t             mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign wr_ptr_nx   = wr_ptr_q + OUT_PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + OUT_PTR_W'(push_cnt_i);
    rd_ptr_d = pop ? rd_ptr_q + OUT_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + OUT_CNT_W'(push_cnt_i) - OUT_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

>>> rtl/arm64_peephole_window_rewriter_unit.sv
// Top level of the ARM64 peephole window rewriter: input stage, window state and result queue.
//
//  Channel | Ports                              | Item
//  --------+------------------------------------+----------------------------------------
//  in      | in_valid_i, in_ready_o, in_data_i  | instr_word, is_final
//  out     | out_valid_o, out_ready_i, out_data_o | out_word, end_of_run, nop_total
//
//  One item is taken per cycle while the result queue has room. An item is registered in the
//  input register, where the window check runs, and the results it releases land in a
//  four-entry result queue, whose occupancy drives out_valid_o.
//  The final item of a buffer can give two results while the queue drains one per cycle when out_ready_i is high.
//  rst_ni clears the window control, the NOP counter and the queue pointers at once.
//  When the queue has fewer than two free entries the input register holds its item and
//  in_ready_o drops until the output side takes results.
module arm64_peephole_window_rewriter_unit
  import apwr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  apwr_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output apwr_out_t out_data_o
);

  // Input register
  logic     in_vld_q;
  apwr_in_t in_q;

  // Window state: pending word, pending flag, skip flag, NOP count
  logic [31:0]          win_a_q, win_a_d;
  logic                 held_q, held_d;
  logic                 skip_q, skip_d;
  logic [NOP_CNT_W-1:0] cnt_q, cnt_d;

  logic        room, advance;
  logic [1:0]  push_cnt;
  apwr_out_t   push0, push1;
  apwr_match_t mres;

  logic [31:0]          last_src, last_word;
  logic                 last_hit;
  logic [NOP_CNT_W-1:0] cnt_pair;

  // Process the held item only when the queue can take both possible results.
  assign advance    = in_vld_q && room;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Check the pending word against the incoming one; a third word exists unless final.
  apwr_match u_match (
    .a_i     (win_a_q),
    .b_i     (in_q.instr_word),
    .third_i (!in_q.is_final),
    .res_o   (mres)
  );

  // Last position of a buffer: only the self-move rule applies.
  assign last_src  = skip_q ? in_q.instr_word : mres.word_b;
  assign last_hit  = is_self_mov(last_src) && (skip_q || !mres.skip);
  assign last_word = last_hit ? NOP_WORD : last_src;
  assign cnt_pair  = (!skip_q && mres.hit) ? sat_inc(cnt_q) : cnt_q;

  always_comb begin
    win_a_d  = win_a_q;
    held_d   = held_q;
    skip_d   = skip_q;
    cnt_d    = cnt_q;
    push_cnt = 2'd0;
    push0    = '{out_word: win_a_q, end_of_run: 1'b0, nop_total: '0};
    push1    = '{out_word: last_word, end_of_run: 1'b1,
                 nop_total: last_hit ? sat_inc(cnt_pair) : cnt_pair};
    if (advance) begin
      if (!held_q) begin
        if (in_q.is_final) begin
          // single-word buffer: pass through
          push_cnt = 2'd1;
          push0    = '{out_word: in_q.instr_word, end_of_run: 1'b1, nop_total: cnt_q};
          cnt_d    = '0;
        end else begin
          win_a_d = in_q.instr_word;
          held_d  = 1'b1;
        end
      end else begin
        push_cnt = 2'd1;
        if (!skip_q) begin
          push0.out_word = mres.word_a;
        end
        if (in_q.is_final) begin
          // flush the last position and return to the reset state
          push_cnt = 2'd2;
          held_d   = 1'b0;
          skip_d   = 1'b0;
          cnt_d    = '0;
        end else begin
          win_a_d = skip_q ? in_q.instr_word : mres.word_b;
          skip_d  = skip_q ? 1'b0 : mres.skip;
          cnt_d   = cnt_pair;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      skip_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      held_q <= held_d;
      skip_q <= skip_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_a_q <= win_a_d;
  end

  apwr_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (push_cnt),
    .push0_i     (push0),
    .push1_i     (push1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> dv/arm64_peephole_window_rewriter_unit_tb.sv
// Self-checking testbench for the ARM64 peephole window rewriter: directed and random buffers.
`timescale 1ns / 1ps

module arm64_peephole_window_rewriter_unit_tb;
  import apwr_pkg::*;

  localparam int ITEM_TARGET = 310;   // rough size of the whole stimulus
  localparam int TAIL_ITEMS  = 40;    // last items go through with no idling
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake before giving up
  localparam int DRAIN_WAIT  = 8;     // settle time after the last result

  // Condition code used when building a branch that is not EQ, NE or AL
  localparam logic [3:0] COND_GT = 4'hC;

  // Instruction shapes the random generator strings together
  typedef enum int {
    PAT_STR_PAIR,
    PAT_LDR_PAIR,
    PAT_STORE_RELOAD,
    PAT_DUP_STORE,
    PAT_SUBS_CMP,
    PAT_CMP_BRANCH,
    PAT_BCOND_OVER_B,
    PAT_MOV_MERGE,
    PAT_SELF_MOV,
    PAT_NOISE
  } pattern_e;

  typedef struct {
    apwr_in_t item;
    bit       drain_first;  // hold this item until every pending result is out
  } feed_t;

  logic      clk_i    = 1'b0;
  logic      rst_ni   = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  apwr_in_t  in_data  = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  apwr_out_t out_data_o;

  arm64_peephole_window_rewriter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Rewrite predictor: window state and NOP count mirrored from the block
  // ---------------------------------------------------------------------------
  logic [31:0]          win_a, win_b;
  bit                   held;
  bit                   skip_pending;
  logic [NOP_CNT_W-1:0] nop_cnt;

  apwr_out_t expected_words[$];
  feed_t     pending_words[$];
  logic [31:0] buf_words[$];

  int  errors;
  int  words_in;
  int  buffers_in;
  int  results_checked;
  int  rewrites_predicted;
  int  quiet_cycles;
  bit  word_taken;
  bit  stim_loaded;
  bit  drain_next;

  function automatic int branch19(logic [31:0] w);
    return int'($signed(w[23:5]));
  endfunction

  function automatic int branch26(logic [31:0] w);
    return int'($signed(w[25:0]));
  endfunction

  function automatic bit fits19(int v);
    return v >= -(1 << 18) && v < (1 << 18);
  endfunction

  function automatic logic [31:0] branch_field(int v);
    return (32'(v) & 32'h7FFFF) << 5;
  endfunction

  task automatic count_nop();
    rewrites_predicted++;
    if (nop_cnt < NOP_CAP) nop_cnt++;
  endtask

  task automatic clear_window();
    win_a = '0;
    win_b = '0;
    held = 1'b0;
    skip_pending = 1'b0;
    nop_cnt = '0;
  endtask

  task automatic emit(logic [31:0] w, bit last);
    apwr_out_t r;
    r.out_word   = w;
    r.end_of_run = last;
    r.nop_total  = last ? nop_cnt : '0;
    expected_words.push_back(r);
  endtask

  // MOV Xd,Xd collapses to NOP
  task automatic drop_self_mov();
    if ((win_a & MOV_REG_MSK) == MOV_REG_PAT && win_a[4:0] == win_a[20:16]) begin
      win_a = NOP_WORD;
      count_nop();
    end
  endtask

  // Check the oldest position against the word after it, in rule priority order
  task automatic fold_window(input bit has_third, output bit skip_after);
    logic [31:0] a, b, base;
    int off;
    int k;
    a = win_a;
    b = win_b;
    skip_after = 1'b0;
    for (k = 0; k < 2; k++) begin
      base = (k == 1) ? LDR_X_BASE : STR_X_BASE;
      if ((a & TOP10_MSK) == base && (b & TOP10_MSK) == base && a[9:5] == b[9:5] &&
          a[4:0] != b[4:0] && b[21:10] == a[21:10] + 12'd1 && a[21:10] <= 12'd63 &&
          !(k == 1 && a[4:0] == a[9:5])) begin
        win_a = ((k == 1) ? LDP_X_BASE : STP_X_BASE) | (32'(a[21:10]) << 15) |
                (32'(b[4:0]) << 10) | (32'(a[9:5]) << 5) | 32'(a[4:0]);
        win_b = NOP_WORD;
        count_nop();
        skip_after = 1'b1;
        return;
      end
    end
    // store followed by a reload of the same slot
    if ((((a & TOP10_MSK) == STR_X_BASE && (b & TOP10_MSK) == LDR_X_BASE) ||
         ((a & TOP10_MSK) == STR_W_BASE && (b & TOP10_MSK) == LDR_W_BASE)) &&
        a[4:0] == b[4:0] && a[9:5] == b[9:5] && a[21:10] == b[21:10]) begin
      win_b = NOP_WORD;
      count_nop();
      return;
    end
    if (a == b && ((a & TOP10_MSK) == STR_X_BASE || (a & TOP10_MSK) == STR_W_BASE)) begin
      win_a = NOP_WORD;
      count_nop();
      return;
    end
    if ((a & SUBS_MSK) == SUBS_PAT && (b & SUBS_MSK) == SUBS_PAT && b[4:0] == REG_ZR &&
        a[9:5] == b[9:5] && a[20:16] == b[20:16]) begin
      win_b = NOP_WORD;
      count_nop();
      skip_after = 1'b1;
      return;
    end
    if ((a & CMP_IMM_MSK) == CMP_IMM_PAT && a[21:10] == 12'd0 && a[9:5] != REG_ZR &&
        (b & BCOND_MSK) == BCOND_PAT && b[3:0] <= COND_NE) begin
      off = branch19(b) + 1;
      if (fits19(off)) begin
        win_a = ((b[3:0] == COND_EQ) ? CBZ_BASE : CBNZ_BASE) | branch_field(off) |
                32'(a[9:5]);
        win_b = NOP_WORD;
        count_nop();
        skip_after = 1'b1;
        return;
      end
    end
    if (has_third && (a & BCOND_MSK) == BCOND_PAT && a[3:0] < COND_AL &&
        b[31:26] == B_OPC && branch19(a) == 2) begin
      off = branch26(b) + 1;
      if (fits19(off)) begin
        win_a = BCOND_PAT | branch_field(off) | 32'(a[3:0] ^ 4'h1);
        win_b = NOP_WORD;
        count_nop();
        skip_after = 1'b1;
        return;
      end
    end
    if ((a & MOVW_MSK) == MOVZ_PAT && (b & MOVW_MSK) == MOVK_PAT && a[4:0] == b[4:0] &&
        a[22:21] == 2'd0 && a[20:5] == 16'd0 && b[22:21] == 2'd0) begin
      win_a = MOVZ_PAT | (32'(b[20:5]) << 5) | 32'(a[4:0]);
      win_b = NOP_WORD;
      count_nop();
      skip_after = 1'b1;
      return;
    end
    drop_self_mov();
  endtask

  // Advance the predictor by one accepted item and queue the results it releases
  task automatic rewrite_step(apwr_in_t it);
    bit sk;
    if (!held) begin
      if (it.is_final) begin
        emit(it.instr_word, 1'b1);
        clear_window();
      end else begin
        win_a = it.instr_word;
        held = 1'b1;
      end
    end else if (skip_pending) begin
      emit(win_a, 1'b0);
      skip_pending = 1'b0;
      win_a = it.instr_word;
      if (it.is_final) begin
        drop_self_mov();
        emit(win_a, 1'b1);
        clear_window();
      end
    end else begin
      win_b = it.instr_word;
      fold_window(!it.is_final, sk);
      emit(win_a, 1'b0);
      win_a = win_b;
      if (!it.is_final) begin
        skip_pending = sk;
      end else begin
        if (!sk) drop_self_mov();
        emit(win_a, 1'b1);
        clear_window();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Instruction builders
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] mem_op(logic [31:0] base, logic [4:0] rt, logic [4:0] rn,
                                         logic [11:0] imm);
    return base | (32'(imm) << 10) | (32'(rn) << 5) | 32'(rt);
  endfunction

  function automatic logic [31:0] subs_op(logic [4:0] rd, logic [4:0] rn, logic [4:0] rm);
    return SUBS_PAT | (32'(rm) << 16) | (32'(rn) << 5) | 32'(rd);
  endfunction

  function automatic logic [31:0] cmp_zero(logic [4:0] rn);
    return CMP_IMM_PAT | (32'(rn) << 5);
  endfunction

  function automatic logic [31:0] bcond_op(int off, logic [3:0] cond);
    return BCOND_PAT | branch_field(off) | 32'(cond);
  endfunction

  function automatic logic [31:0] b_op(int off);
    return {B_OPC, 26'(off)};
  endfunction

  function automatic logic [31:0] movw_op(logic [31:0] pat, logic [4:0] rd, logic [15:0] imm);
    return pat | (32'(imm) << 5) | 32'(rd);
  endfunction

  function automatic logic [31:0] mov_op(logic [4:0] rd, logic [4:0] rm);
    return MOV_REG_PAT | (32'(rm) << 16) | 32'(rd);
  endfunction

  // Favor a few low registers so operands collide often; keep SP/ZR in the mix
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(3, 0) == 0) ? 5'($urandom_range(31, 0)) : 5'($urandom_range(7, 0));
  endfunction

  // Branch offsets: mostly short, sometimes right at or just below the 19-bit limit
  function automatic int pick_offset();
    case ($urandom_range(5, 0))
      0: return (1 << 18) - 1;
      1: return -(1 << 18);
      2: return (1 << 18) - 2;
      default: return $urandom_range(200, 0) - 100;
    endcase
  endfunction

  task automatic push_word(logic [31:0] w, bit fin);
    feed_t f;
    f.item.instr_word = w;
    f.item.is_final = fin;
    f.drain_first = drain_next;
    drain_next = 1'b0;
    pending_words.push_back(f);
  endtask

  task automatic append_pattern(pattern_e kind);
    logic [4:0]  r1, r2, r3;
    logic [11:0] imm;
    logic [31:0] base, w;
    int first;
    first = buf_words.size();
    r1 = pick_reg();
    r2 = pick_reg();
    r3 = pick_reg();
    base = $urandom_range(1, 0) ? STR_X_BASE : STR_W_BASE;
    case (kind)
      PAT_STR_PAIR, PAT_LDR_PAIR: begin
        base = (kind == PAT_LDR_PAIR) ? LDR_X_BASE : STR_X_BASE;
        imm = 12'($urandom_range(70, 0));
        buf_words.push_back(mem_op(base, r1, r3, imm));
        buf_words.push_back(mem_op(base, r2, r3, imm + 12'd1));
      end
      PAT_STORE_RELOAD: begin
        imm = 12'($urandom_range(4095, 0));
        buf_words.push_back(mem_op(base, r1, r3, imm));
        buf_words.push_back(mem_op(base | 32'h0040_0000, r1, r3, imm));
      end
      PAT_DUP_STORE: begin
        w = mem_op(base, r1, r3, 12'($urandom_range(4095, 0)));
        buf_words.push_back(w);
        buf_words.push_back(w);
      end
      PAT_SUBS_CMP: begin
        buf_words.push_back(subs_op(r1, r2, r3));
        buf_words.push_back(subs_op(REG_ZR, r2, r3));
      end
      PAT_CMP_BRANCH: begin
        buf_words.push_back(cmp_zero(r1) | (32'($urandom_range(1, 0)) << 22));
        buf_words.push_back(bcond_op(pick_offset(), 4'($urandom_range(2, 0))));
      end
      PAT_BCOND_OVER_B: begin
        buf_words.push_back(bcond_op(2, 4'($urandom_range(15, 0))));
        buf_words.push_back(b_op(($urandom_range(4, 0) == 0) ?
                                 $urandom_range(1 << 25, 1 << 17) : pick_offset()));
        if ($urandom_range(1, 0)) buf_words.push_back($urandom());
      end
      PAT_MOV_MERGE: begin
        buf_words.push_back(movw_op(MOVZ_PAT, r1, 16'd0));
        buf_words.push_back(movw_op(MOVK_PAT, r1, 16'($urandom_range(65535, 0))));
      end
      PAT_SELF_MOV: buf_words.push_back(mov_op(r1, $urandom_range(1, 0) ? r1 : r2));
      default: buf_words.push_back($urandom());
    endcase
    // break the pattern now and then by flipping one bit of one of its words
    if ($urandom_range(99, 0) < 20) begin
      first = $urandom_range(buf_words.size() - 1, first);
      buf_words[first] = buf_words[first] ^ (32'h1 << $urandom_range(31, 0));
    end
  endtask

  task automatic queue_buffer();
    int nfrag;
    buf_words.delete();
    nfrag = ($urandom_range(9, 0) == 0) ? $urandom_range(12, 6) : $urandom_range(4, 1);
    repeat (nfrag) append_pattern(pattern_e'($urandom_range(int'(PAT_NOISE), 0)));
    if ($urandom_range(14, 0) == 0) drain_next = 1'b1;
    foreach (buf_words[i]) push_word(buf_words[i], i == buf_words.size() - 1);
  endtask

  task automatic queue_directed();
    // single-word buffer passes through untouched, even a self-move
    push_word(mov_op(5'd3, 5'd3), 1'b1);
    // store pair at the largest offset, load pair that clobbers its base,
    // compare of SP, compare with branch to CBNZ, self-move on the last position
    push_word(mem_op(STR_X_BASE, 5'd1, 5'd2, 12'd63), 1'b0);
    push_word(mem_op(STR_X_BASE, 5'd4, 5'd2, 12'd64), 1'b0);
    push_word(mem_op(LDR_X_BASE, 5'd5, 5'd5, 12'd0), 1'b0);
    push_word(mem_op(LDR_X_BASE, 5'd6, 5'd5, 12'd1), 1'b0);
    push_word(cmp_zero(REG_ZR), 1'b0);
    push_word(bcond_op(16, COND_EQ), 1'b0);
    push_word(cmp_zero(5'd7), 1'b0);
    push_word(bcond_op(16, COND_NE), 1'b0);
    push_word(mov_op(5'd9, 5'd9), 1'b1);
    // reload, duplicate store, SUBS+CMP, branch inversion, move merge,
    // AL condition left alone, CBZ offset out of range, all-ones word at the end
    push_word(mem_op(STR_W_BASE, 5'd1, 5'd3, 12'd5), 1'b0);
    push_word(mem_op(LDR_W_BASE, 5'd1, 5'd3, 12'd5), 1'b0);
    push_word(mem_op(STR_X_BASE, 5'd2, 5'd4, 12'hFFF), 1'b0);
    push_word(mem_op(STR_X_BASE, 5'd2, 5'd4, 12'hFFF), 1'b0);
    push_word(subs_op(5'd2, 5'd3, 5'd4), 1'b0);
    push_word(subs_op(REG_ZR, 5'd3, 5'd4), 1'b0);
    push_word(bcond_op(2, COND_GT), 1'b0);
    push_word(b_op(-100), 1'b0);
    push_word(movw_op(MOVZ_PAT, 5'd5, 16'd0), 1'b0);
    push_word(movw_op(MOVK_PAT, 5'd5, 16'hFFFF), 1'b0);
    push_word(bcond_op(2, COND_AL), 1'b0);
    push_word(b_op(5), 1'b0);
    push_word(cmp_zero(5'd8), 1'b0);
    push_word(bcond_op((1 << 18) - 1, COND_EQ), 1'b0);
    push_word(32'hFFFF_FFFF, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Idling control: each side re-rolls its idle rate now and then, so the run
  // has busy phases, gappy phases and clean stretches; the tail has no idling.
  // ---------------------------------------------------------------------------
  int send_gap, send_pct;
  int hold_gap, hold_pct;

  function automatic int pick_pct();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 8;
      default: return 25;
    endcase
  endfunction

  function automatic bit quiet_tail();
    return stim_loaded && pending_words.size() < TAIL_ITEMS;
  endfunction

  // Driver: present items at the falling edge, hold each one until taken
  always @(negedge clk_i) begin : feed_words
    logic     nxt_valid;
    apwr_in_t nxt_data;
    nxt_valid = in_valid;
    nxt_data = in_data;
    if (in_valid && word_taken) nxt_valid = 1'b0;
    word_taken = 1'b0;
    if ($urandom_range(63, 0) == 0) send_pct = pick_pct();
    if (quiet_tail()) send_gap = 0;
    if (rst_ni && !nxt_valid) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (pending_words.size() != 0) begin
        if (pending_words[0].drain_first && expected_words.size() != 0) begin
          // hold off until the block has handed back everything it owes
        end else if (!quiet_tail() && $urandom_range(99, 0) < send_pct) begin
          send_gap = $urandom_range(15, 1) - 1;
        end else begin
          nxt_data = pending_words[0].item;
          nxt_valid = 1'b1;
          pending_words.pop_front();
        end
      end
    end
    in_valid <= nxt_valid;
    in_data <= nxt_data;
  end

  // Receiver: stall out_ready in bursts
  always @(negedge clk_i) begin : take_results
    if ($urandom_range(63, 0) == 0) hold_pct = pick_pct();
    if (quiet_tail()) begin
      hold_gap = 0;
      out_ready <= 1'b1;
    end else if (hold_gap != 0) begin
      hold_gap--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99, 0) < hold_pct) begin
      hold_gap = $urandom_range(15, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted item, check each accepted result
  always @(posedge clk_i) begin : watch_ports
    apwr_out_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        rewrite_step(in_data);
        word_taken = 1'b1;
        words_in++;
        if (in_data.is_final) buffers_in++;
      end
      if (out_valid_o && out_ready) begin
        results_checked++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got word %h end %b nops %0d",
                   $time, out_data_o.out_word, out_data_o.end_of_run, out_data_o.nop_total);
        end else begin
          want = expected_words.pop_front();
          if (out_data_o.out_word !== want.out_word ||
              out_data_o.end_of_run !== want.end_of_run ||
              out_data_o.nop_total !== want.nop_total) begin
            errors++;
            $display("%0t: result %0d mismatch, expected %h/%b/%0d, got %h/%b/%0d",
                     $time, results_checked, want.out_word, want.end_of_run, want.nop_total,
                     out_data_o.out_word, out_data_o.end_of_run, out_data_o.nop_total);
          end
        end
      end
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Watchdog: a hung handshake ends the run
  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("%0t: no handshake for %0d cycles, %0d results still owed",
             $time, STALL_LIMIT, expected_words.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : run_test
    send_pct = pick_pct();
    hold_pct = pick_pct();
    clear_window();
    queue_directed();
    drain_next = 1'b1;  // let the directed part drain fully before random traffic
    while (pending_words.size() < ITEM_TARGET) queue_buffer();
    stim_loaded = 1'b1;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Fed %0d words in %0d buffers; %0d rewrites predicted, %0d results checked.",
             words_in, buffers_in, rewrites_predicted, results_checked);
    $display("Mismatches or stray results: %0d", errors);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
